>>> design/tmg_pkg.sv
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared types and codes of the triangular membership grade unit.
// ----------------------------------------------------------------------------
package tmg_pkg;

  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_RANGE = 2'd1,
    ST_BAD_PARAMS   = 2'd2
  } status_e;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CORNER_LEFT   = 3'd0;
  localparam cfg_idx_t CFG_CORNER_PEAK   = 3'd1;
  localparam cfg_idx_t CFG_CORNER_RIGHT  = 3'd2;
  localparam cfg_idx_t CFG_UNIVERSE_LOW  = 3'd3;
  localparam cfg_idx_t CFG_UNIVERSE_HIGH = 3'd4;

endpackage

>>> design/tmg_cfg_if.sv
// ----------------------------------------------------------------------------
// tmg_cfg_if
// Register write channel: index and data under valid/ready.
// ----------------------------------------------------------------------------
interface tmg_cfg_if #(
  parameter int unsigned DataBits = 16
);
  import tmg_pkg::*;

  logic                valid;
  logic                ready;
  cfg_idx_t            index;
  logic [DataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

>>> design/tmg_sample_if.sv
// ----------------------------------------------------------------------------
// tmg_sample_if
// Sample stream: one signed sample per item under valid/ready.
// ----------------------------------------------------------------------------
interface tmg_sample_if #(
  parameter int unsigned SampleBits = 16
);
  import tmg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

>>> design/tmg_result_if.sv
// ----------------------------------------------------------------------------
// tmg_result_if
// Result stream: membership grade and status per item under valid/ready.
// ----------------------------------------------------------------------------
interface tmg_result_if #(
  parameter int unsigned GradeBits = 16
);
  import tmg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [GradeBits-1:0] grade;
  status_e              status;

  modport source (output valid, output grade, output status, input ready);
  modport sink   (input valid, input grade, input status, output ready);

endinterface

>>> design/triangular_membership_grade_unit.sv
// ----------------------------------------------------------------------------
// triangular_membership_grade_unit
// Triangular fuzzy membership grade of a signed sample, with a pipelined
// restoring divider producing one quotient bit per stage.
//
//   channel    dir  handshake        payload
//   cfg_i      in   valid / ready    index, data (SAMPLE_BITS)
//   sample_i   in   valid / ready    sample (SAMPLE_BITS, signed)
//   result_o   out  valid / ready    grade (GRADE_FRAC_BITS+1), status
//
// One item per cycle while the output is not held. The pipe is the input
// and classify registers, a divider chain of GRADE_FRAC_BITS + 1 one-bit
// stages, and the output register. All stages share one enable: when the
// output holds an item not yet taken, the whole pipe freezes. Reset clears
// valid bits and loads the default corners; cfg_i is always ready.
// ----------------------------------------------------------------------------
module triangular_membership_grade_unit #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned GRADE_FRAC_BITS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tmg_cfg_if.sink       cfg_i,
  tmg_sample_if.sink    sample_i,
  tmg_result_if.source  result_o
);
  import tmg_pkg::*;

  localparam int unsigned SW   = SAMPLE_BITS;
  localparam int unsigned DW   = SAMPLE_BITS + 1;
  localparam int unsigned GW   = GRADE_FRAC_BITS + 1;
  localparam int unsigned NDIV = GRADE_FRAC_BITS;

  localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};

  // configuration registers
  logic signed [SW-1:0] corner_left_q, corner_peak_q, corner_right_q;
  logic signed [SW-1:0] universe_low_q, universe_high_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_left_q   <= SMin;
      corner_peak_q   <= '0;
      corner_right_q  <= SMax;
      universe_low_q  <= SMin;
      universe_high_q <= SMax;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CORNER_LEFT:   corner_left_q   <= cfg_i.data;
        CFG_CORNER_PEAK:   corner_peak_q   <= cfg_i.data;
        CFG_CORNER_RIGHT:  corner_right_q  <= cfg_i.data;
        CFG_UNIVERSE_LOW:  universe_low_q  <= cfg_i.data;
        CFG_UNIVERSE_HIGH: universe_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // global pipeline enable
  logic res_valid_q;
  logic advance;
  assign advance        = !res_valid_q || result_o.ready;
  assign sample_i.ready = advance;

  // stage 0: input register
  logic                 v0_q;
  logic signed [SW-1:0] x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (advance) begin
      v0_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x_q <= sample_i.sample;
    end
  end

  // stage 1: classify, pick numerator and denominator
  logic                 bad, outside, rising, zero_region;
  logic signed [DW-1:0] xe, ae, be, ce;
  logic [DW-1:0]        num_d, den_d;
  status_e              st_d;
  logic                 gz_d;

  always_comb begin
    bad         = (corner_left_q > corner_peak_q) || (corner_peak_q > corner_right_q);
    outside     = (x_q < universe_low_q) || (x_q > universe_high_q);
    rising      = x_q < corner_peak_q;
    zero_region = (x_q <= corner_left_q) || (x_q >= corner_right_q);
    xe = {x_q[SW-1], x_q};
    ae = {corner_left_q[SW-1], corner_left_q};
    be = {corner_peak_q[SW-1], corner_peak_q};
    ce = {corner_right_q[SW-1], corner_right_q};
    num_d = rising ? DW'(xe - ae) : DW'(ce - xe);
    den_d = rising ? DW'(be - ae) : DW'(ce - be);
    if (bad) begin
      st_d = ST_BAD_PARAMS;
    end else if (outside) begin
      st_d = ST_OUT_OF_RANGE;
    end else begin
      st_d = ST_OK;
    end
    gz_d = bad || outside || zero_region;
  end

  logic          v1_q, gz1_q;
  logic [DW-1:0] num1_q, den1_q;
  status_e       st1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      num1_q <= num_d;
      den1_q <= den_d;
      st1_q  <= st_d;
      gz1_q  <= gz_d;
    end
  end

  // divider: stage 0 gives the integer bit (num >= den), then one bit a stage
  logic [DW-1:0] rem_q [NDIV+1];
  logic [DW-1:0] den_q [NDIV+1];
  logic [GW-1:0] quo_q [NDIV+1];
  status_e       st_q  [NDIV+1];
  logic [NDIV:0] gz_q;
  logic [NDIV:0] vld_q;

  logic ge0;
  assign ge0 = num1_q >= den1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rem_q[0] <= ge0 ? (num1_q - den1_q) : num1_q;
      den_q[0] <= den1_q;
      quo_q[0] <= {ge0, {(GW-1){1'b0}}};
      st_q[0]  <= st1_q;
      gz_q[0]  <= gz1_q;
    end
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    logic [DW:0]   sh;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [GW-1:0] quo_d;

    always_comb begin
      sh    = {rem_q[j-1], 1'b0};
      ge    = sh >= {1'b0, den_q[j-1]};
      rem_d = ge ? DW'(sh - {1'b0, den_q[j-1]}) : DW'(sh);
      quo_d = quo_q[j-1];
      quo_d[GRADE_FRAC_BITS-j] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (advance) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_d;
        st_q[j]  <= st_q[j-1];
        gz_q[j]  <= gz_q[j-1];
      end
    end
  end

  // output register
  logic [GW-1:0] grade_q;
  status_e       status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= vld_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      grade_q  <= gz_q[NDIV] ? '0 : quo_q[NDIV];
      status_q <= st_q[NDIV];
    end
  end

  assign result_o.valid  = res_valid_q;
  assign result_o.grade  = grade_q;
  assign result_o.status = status_q;

endmodule

>>> sim/triangular_membership_grade_unit_tb.sv
// ----------------------------------------------------------------------------
// triangular_membership_grade_unit_tb
// Self-checking bench: a short table of directed samples and register writes,
// then random settings, each followed by a burst of samples. Every grade and
// status is predicted or taken from the table at acceptance and compared in order at the output.
// ----------------------------------------------------------------------------
module triangular_membership_grade_unit_tb;
  import tmg_pkg::*;

  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned GRADE_FRAC_BITS = 15;
  localparam int unsigned GRADE_BITS      = GRADE_FRAC_BITS + 1;
  localparam int unsigned LATENCY         = GRADE_FRAC_BITS + 4;
  localparam int unsigned RANDOM_ITEMS    = 500;
  localparam int unsigned DIRECTED_ROWS   = 48;
  localparam int unsigned IDLE_PCT        = 7;

  // indexes with no register behind them
  localparam cfg_idx_t IDX_SPARE_FIRST = 3'd5;
  localparam cfg_idx_t IDX_SPARE_LAST  = 3'd7;

  localparam logic [GRADE_BITS-1:0] GRADE_ONE = GRADE_BITS'(1 << GRADE_FRAC_BITS);

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_t              idx;
    logic [SAMPLE_BITS-1:0] value;
    logic                  known;
    logic [GRADE_BITS-1:0] grade;
    status_e               status;
  } stim_row_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic [GRADE_BITS-1:0]  grade;
    status_e                status;
  } grade_item_t;

  logic clk_i;
  logic rst_ni;

  tmg_cfg_if    #(.DataBits(SAMPLE_BITS))  cfg_bus ();
  tmg_sample_if #(.SampleBits(SAMPLE_BITS)) smp_bus ();
  tmg_result_if #(.GradeBits(GRADE_BITS))  res_bus ();

  triangular_membership_grade_unit #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GRADE_FRAC_BITS(GRADE_FRAC_BITS)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .sample_i(smp_bus),
    .result_o(res_bus)
  );

  // bench copy of the registers
  logic signed [SAMPLE_BITS-1:0] corner_a, corner_b, corner_c, uni_lo, uni_hi;

  grade_item_t grades_due[$];
  stim_row_t   directed_rows [DIRECTED_ROWS];

  int  failures;
  int  samples_sent;
  int  results_seen;
  int  reg_writes;
  int  settings_used;
  int  status_count [3];
  bit  steady;
  bit  cfg_active;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // prediction
  // -------------------------------------------------------------------------
  function automatic logic [GRADE_BITS-1:0] edge_fraction(longint num, longint den);
    if (den <= 0) return GRADE_ONE;
    return GRADE_BITS'((num <<< GRADE_FRAC_BITS) / den);
  endfunction

  function automatic grade_item_t membership_grade(logic [SAMPLE_BITS-1:0] raw);
    grade_item_t r;
    longint      x;
    x        = longint'($signed(raw));
    r.sample = raw;
    r.grade  = '0;
    r.status = ST_OK;
    if (corner_a > corner_b || corner_b > corner_c) begin
      r.status = ST_BAD_PARAMS;
    end else if (x < uni_lo || x > uni_hi) begin
      r.status = ST_OUT_OF_RANGE;
    end else if (x <= corner_a) begin
      r.grade = '0;
    end else if (x < corner_b) begin
      r.grade = edge_fraction(x - corner_a, longint'(corner_b) - corner_a);
    end else if (x < corner_c) begin
      r.grade = edge_fraction(longint'(corner_c) - x, longint'(corner_c) - corner_b);
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // table helpers
  // -------------------------------------------------------------------------
  function automatic stim_row_t wr(cfg_idx_t idx, int v);
    stim_row_t r;
    r.kind = ROW_WRITE; r.idx = idx; r.value = SAMPLE_BITS'(v);
    r.known = 1'b0; r.grade = '0; r.status = ST_OK;
    return r;
  endfunction

  function automatic stim_row_t smp(int v);
    stim_row_t r;
    r = wr(CFG_CORNER_LEFT, v);
    r.kind = ROW_SAMPLE;
    return r;
  endfunction

  function automatic stim_row_t chk(int v, int g, status_e st);
    stim_row_t r;
    r = smp(v);
    r.known = 1'b1; r.grade = GRADE_BITS'(g); r.status = st;
    return r;
  endfunction

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int clamp16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // drivers; every task is entered and left just after a falling edge
  // -------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_t idx, logic [SAMPLE_BITS-1:0] data);
    if (!cfg_active) begin
      // block must be idle before any register changes
      smp_bus.valid <= 1'b0;
      while (grades_due.size() != 0) @(negedge clk_i);
      cfg_active = 1'b1;
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      CFG_CORNER_LEFT:   corner_a = data;
      CFG_CORNER_PEAK:   corner_b = data;
      CFG_CORNER_RIGHT:  corner_c = data;
      CFG_UNIVERSE_LOW:  uni_lo   = data;
      CFG_UNIVERSE_HIGH: uni_hi   = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic send_sample(logic [SAMPLE_BITS-1:0] s, logic known,
                             logic [GRADE_BITS-1:0] g, status_e st);
    grade_item_t e;
    if (cfg_active) begin
      cfg_bus.valid <= 1'b0;
      cfg_active = 1'b0;
      settings_used++;
    end
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      smp_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_bus.valid  <= 1'b1;
    smp_bus.sample <= s;
    @(posedge clk_i);
    while (!smp_bus.ready) @(posedge clk_i);
    if (known) begin
      e.sample = s; e.grade = g; e.status = st;
    end else begin
      e = membership_grade(s);
    end
    grades_due.push_back(e);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic pick_setting();
    int v0, v1, v2, t, lo, hi, mode, umode;
    mode = $urandom_range(0, 9);
    v0 = rnd16(); v1 = rnd16(); v2 = rnd16();
    if (mode == 2) begin
      // narrow triangle, steep edges
      v0 = int'($urandom_range(0, 65535 - 64)) - 32768;
      v1 = v0 + int'($urandom_range(0, 16));
      v2 = v1 + int'($urandom_range(0, 16));
    end
    if (mode != 1) begin
      if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
      if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
      if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
    end else if (v0 <= v1 && v1 <= v2) begin
      v0 = 32767; v1 = -32768;
    end
    if (mode == 0) begin
      v0 = -32768; v2 = 32767;
      case ($urandom_range(0, 3))
        0: v1 = -32768;
        1: v1 = 0;
        2: v1 = 32767;
        default: ;
      endcase
    end
    umode = $urandom_range(0, 9);
    lo = -32768; hi = 32767;
    if (umode == 7 || umode == 8) begin
      lo = clamp16(v0 - 8 + int'($urandom_range(0, 16)));
      hi = clamp16(v2 - 8 + int'($urandom_range(0, 16)));
    end else if (umode == 9) begin
      lo = rnd16(); hi = rnd16();
      if (lo < hi) begin t = lo; lo = hi; hi = t; end
    end
    write_reg(CFG_CORNER_LEFT,   SAMPLE_BITS'(v0));
    write_reg(CFG_CORNER_PEAK,   SAMPLE_BITS'(v1));
    write_reg(CFG_CORNER_RIGHT,  SAMPLE_BITS'(v2));
    write_reg(CFG_UNIVERSE_LOW,  SAMPLE_BITS'(lo));
    write_reg(CFG_UNIVERSE_HIGH, SAMPLE_BITS'(hi));
    if ($urandom_range(0, 3) == 0)
      write_reg(cfg_idx_t'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)),
                SAMPLE_BITS'(rnd16()));
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int lo, hi, r;
    lo = int'(corner_a); hi = int'(corner_a);
    if (corner_b < lo) lo = int'(corner_b);
    if (corner_c < lo) lo = int'(corner_c);
    if (corner_b > hi) hi = int'(corner_b);
    if (corner_c > hi) hi = int'(corner_c);
    lo = clamp16(lo - 4);
    hi = clamp16(hi + 4);
    r  = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return corner_a;
        1: return corner_b;
        2: return corner_c;
        3: return uni_lo;
        default: return uni_hi;
      endcase
    end
    if (r < 75) return SAMPLE_BITS'(lo + int'($urandom_range(0, hi - lo)));
    return SAMPLE_BITS'(rnd16());
  endfunction

  // -------------------------------------------------------------------------
  // output side
  // -------------------------------------------------------------------------
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : grade_check
    grade_item_t e;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (grades_due.size() == 0) begin
        $display("%0t: result with nothing pending: grade %0d status %0d",
                 $time, res_bus.grade, res_bus.status);
        failures++;
      end else begin
        e = grades_due.pop_front();
        if (e.status <= ST_BAD_PARAMS) status_count[e.status]++;
        if (res_bus.grade !== e.grade) begin
          $display("%0t: sample %0d grade expected %0d actual %0d",
                   $time, $signed(e.sample), e.grade, res_bus.grade);
          failures++;
        end
        if (res_bus.status !== e.status) begin
          $display("%0t: sample %0d status expected %0d actual %0d",
                   $time, $signed(e.sample), e.status, res_bus.status);
          failures++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin
    int phase, burst, target;
    rst_ni         = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_CORNER_LEFT;
    cfg_bus.data   = '0;
    smp_bus.valid  = 1'b0;
    smp_bus.sample = '0;
    failures = 0; samples_sent = 0; results_seen = 0;
    reg_writes = 0; settings_used = 1;
    status_count = '{0, 0, 0};
    steady = 1'b0; cfg_active = 1'b0;
    corner_a = SAMPLE_BITS'(-32768); corner_b = '0; corner_c = SAMPLE_BITS'(32767);
    uni_lo   = SAMPLE_BITS'(-32768); uni_hi   = SAMPLE_BITS'(32767);

    directed_rows = '{
      chk(0, 32768, ST_OK),             // peak at reset corners
      chk(-32768, 0, ST_OK),
      chk(32767, 0, ST_OK),
      smp(-16384),
      smp(1),
      wr(CFG_UNIVERSE_LOW, -100),
      wr(CFG_UNIVERSE_HIGH, 100),
      chk(-101, 0, ST_OUT_OF_RANGE),
      chk(101, 0, ST_OUT_OF_RANGE),
      smp(100),
      smp(-100),
      wr(CFG_UNIVERSE_LOW, -32768),
      wr(CFG_UNIVERSE_HIGH, 32767),
      wr(CFG_CORNER_LEFT, -50),
      wr(CFG_CORNER_PEAK, 50),
      wr(CFG_CORNER_RIGHT, 50),
      chk(50, 0, ST_OK),                // peak sits on right foot
      smp(49),
      smp(-49),
      wr(CFG_CORNER_PEAK, -50),
      chk(-50, 0, ST_OK),               // peak sits on left foot
      smp(-49),
      wr(CFG_CORNER_LEFT, 10),
      chk(0, 0, ST_BAD_PARAMS),         // left above peak
      wr(CFG_CORNER_LEFT, -10),
      wr(CFG_CORNER_PEAK, 20),
      wr(CFG_CORNER_RIGHT, 10),
      wr(CFG_UNIVERSE_LOW, 100),
      wr(CFG_UNIVERSE_HIGH, 200),
      chk(0, 0, ST_BAD_PARAMS),         // order check wins over range
      wr(CFG_CORNER_RIGHT, 30),
      wr(CFG_UNIVERSE_LOW, 5),
      wr(CFG_UNIVERSE_HIGH, -5),
      chk(0, 0, ST_OUT_OF_RANGE),       // inverted universe
      wr(IDX_SPARE_FIRST, 16'h1234),
      wr(IDX_SPARE_LAST, -1),
      chk(0, 0, ST_OUT_OF_RANGE),
      wr(CFG_UNIVERSE_LOW, -32768),
      wr(CFG_UNIVERSE_HIGH, 32767),
      wr(CFG_CORNER_LEFT, -32768),
      wr(CFG_CORNER_PEAK, 32767),
      wr(CFG_CORNER_RIGHT, 32767),
      smp(32766),
      chk(32767, 0, ST_OK),
      wr(CFG_CORNER_PEAK, -32768),
      smp(-32767),
      chk(-32768, 0, ST_OK),
      smp(0)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      else
        send_sample(directed_rows[i].value, directed_rows[i].known,
                    directed_rows[i].grade, directed_rows[i].status);
    end

    target = samples_sent + RANDOM_ITEMS;
    phase  = 0;
    while (samples_sent < target) begin
      pick_setting();
      steady = (phase >= 4 && phase <= 6);
      burst  = $urandom_range(10, 50);
      repeat (burst) send_sample(pick_sample(), 1'b0, '0, ST_OK);
      phase++;
    end
    steady = 1'b0;

    smp_bus.valid <= 1'b0;
    while (grades_due.size() != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("covered %0d samples under %0d settings, %0d register writes",
             samples_sent, settings_used, reg_writes);
    $display("results: %0d in range, %0d outside universe, %0d corners out of order",
             status_count[ST_OK], status_count[ST_OUT_OF_RANGE],
             status_count[ST_BAD_PARAMS]);
    if (failures == 0 && grades_due.size() == 0)
      $display("triangular_membership_grade_unit: match");
    else
      $display("triangular_membership_grade_unit: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results pending", grades_due.size());
    $display("triangular_membership_grade_unit: mismatch");
    $finish;
  end

endmodule
